>>> rtl/core/sfs_pkg.sv
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int TIME_BITS  = 16;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int ACC_W      = TIME_BITS + 1;
    localparam int PART_W     = 8;
    localparam int ACTION_W   = 3;
    localparam int TICKS_W    = 16;
    localparam int INDEX_W    = 4;
    localparam int LENGTH_W   = 16;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COUNT_W;
    localparam int ENTRY_W    = PART_W + TIME_BITS;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_PAUSE = 3'd2,
        ACT_STOP  = 3'd3,
        ACT_WRITE = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 1'd0,
        CFG_PLAY_ONCE   = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic capture;
        logic acc_add;
        logic step;
        logic finish;
        logic load_part;
        logic restart;
        logic resume;
        logic pause;
        logic stop;
        logic write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                playing;
        logic                paused;
        logic                covers;
        logic                last_once;
        logic                out_free;
    } t_status;

endpackage

>>> rtl/core/sfs_in_if.sv
`timescale 1ns / 1ps

interface sfs_in_if;
    import sfs_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TICKS_W-1:0]  ticks;
    logic [INDEX_W-1:0]  entry_index;
    logic [PART_W-1:0]   entry_part;
    logic [LENGTH_W-1:0] entry_length;

    modport source (
        output valid, action, ticks, entry_index, entry_part, entry_length,
        input  ready
    );
    modport sink (
        input  valid, action, ticks, entry_index, entry_part, entry_length,
        output ready
    );
endinterface

>>> rtl/core/sfs_out_if.sv
`timescale 1ns / 1ps

interface sfs_out_if;
    import sfs_pkg::*;

    logic               valid;
    logic               ready;
    logic [PART_W-1:0]  sprite_part;
    logic [FRAME_W-1:0] frame_index;
    logic               playing;
    logic               paused;

    modport source (
        output valid, sprite_part, frame_index, playing, paused,
        input  ready
    );
    modport sink (
        input  valid, sprite_part, frame_index, playing, paused,
        output ready
    );
endinterface

>>> rtl/core/sprite_frame_sequencer.sv
`timescale 1ns / 1ps
// Flow: each transfer in is captured and decoded; a restart then loads frame 0's part and a playing
// tick adds its ticks, then compares and steps frames, before the result is registered on output.
// Throughput: one item at a time, a new transfer in taken once the previous result is
// registered; the tick loop steps one frame per cycle through the frame table read port.
// Reset (synchronous, active low) clears frame, time, flags, shown part and output valid, and sets
// the frame count to 1; the frame table is not cleared and is undefined until written.

module sprite_frame_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sfs_in_if.sink                         i_in,
    sfs_out_if.source                      o_out,
    input  logic                           i_cfg_wr_en,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import sfs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    sfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sfs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_action       (i_in.action),
        .i_ticks        (i_in.ticks),
        .i_entry_index  (i_in.entry_index),
        .i_entry_part   (i_in.entry_part),
        .i_entry_length (i_in.entry_length),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_sprite_part  (o_out.sprite_part),
        .o_frame_index  (o_out.frame_index),
        .o_playing      (o_out.playing),
        .o_paused       (o_out.paused)
    );

endmodule

>>> rtl/core/sfs_datapath.sv
`timescale 1ns / 1ps

module sfs_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfs_pkg::t_cmd                 i_cmd,
    output sfs_pkg::t_status              o_status,
    input  logic [sfs_pkg::ACTION_W-1:0]  i_action,
    input  logic [sfs_pkg::TICKS_W-1:0]   i_ticks,
    input  logic [sfs_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [sfs_pkg::PART_W-1:0]    i_entry_part,
    input  logic [sfs_pkg::LENGTH_W-1:0]  i_entry_length,
    input  logic                          i_cfg_wr_en,
    input  logic [sfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfs_pkg::PART_W-1:0]    o_sprite_part,
    output logic [sfs_pkg::FRAME_W-1:0]   o_frame_index,
    output logic                          o_playing,
    output logic                          o_paused
);
    import sfs_pkg::*;

    logic [ENTRY_W-1:0]   r_mem [MAX_FRAMES];
    logic [ENTRY_W-1:0]   r_rd_entry;
    logic [ACTION_W-1:0]  r_action;
    logic [TICKS_W-1:0]   r_ticks;
    logic [INDEX_W-1:0]   r_index;
    logic [PART_W-1:0]    r_part;
    logic [LENGTH_W-1:0]  r_length;
    logic [FRAME_W-1:0]   r_frame;
    logic [ACC_W-1:0]     r_acc;
    logic                 r_playing;
    logic                 r_paused;
    logic [PART_W-1:0]    r_shown;
    logic [COUNT_W-1:0]   r_frame_count;
    logic                 r_play_once;
    logic                 r_out_valid;
    logic [PART_W-1:0]    r_out_part;
    logic [FRAME_W-1:0]   r_out_frame;
    logic                 r_out_playing;
    logic                 r_out_paused;

    logic [FRAME_W-1:0]   n_frame;
    logic [FRAME_W-1:0]   rd_addr;
    logic [TIME_BITS-1:0] rd_len;
    logic [TIME_BITS-1:0] len_eff;
    logic [ACC_W:0]       acc_sum;
    logic [ACC_W-1:0]     acc_sat;
    logic [FRAME_W-1:0]   last_idx;
    logic                 last;
    logic                 out_free;

    always_comb begin
        if (r_frame_count == '0) begin
            last_idx = '0;
        end else if (r_frame_count > COUNT_W'(MAX_FRAMES)) begin
            last_idx = FRAME_W'(MAX_FRAMES - 1);
        end else begin
            last_idx = FRAME_W'(r_frame_count - COUNT_W'(1));
        end
    end

    assign last    = (r_frame >= last_idx);
    assign n_frame = last ? '0 : r_frame + FRAME_W'(1);
    assign rd_addr = i_cmd.step ? n_frame : (i_cmd.restart ? '0 : r_frame);
    assign rd_len  = r_rd_entry[TIME_BITS-1:0];
    assign len_eff = (rd_len == '0) ? TIME_BITS'(1) : rd_len;
    assign acc_sum = {1'b0, r_acc} + (ACC_W+1)'(r_ticks[TIME_BITS-1:0]);
    assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.action    = r_action;
    assign o_status.playing   = r_playing;
    assign o_status.paused    = r_paused;
    assign o_status.covers    = (r_acc >= {1'b0, len_eff});
    assign o_status.last_once = last && r_play_once;
    assign o_status.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[r_index] <= {r_part, TIME_BITS'(r_length)};
        end
        r_rd_entry <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_ticks  <= i_ticks;
            r_index  <= i_entry_index;
            r_part   <= i_entry_part;
            r_length <= i_entry_length;
        end
        if (i_cmd.out_load) begin
            r_out_part    <= r_shown;
            r_out_frame   <= r_frame;
            r_out_playing <= r_playing;
            r_out_paused  <= r_paused;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame       <= '0;
            r_acc         <= '0;
            r_playing     <= 1'b0;
            r_paused      <= 1'b0;
            r_shown       <= '0;
            r_frame_count <= COUNT_W'(1);
            r_play_once   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_COUNT: r_frame_count <= i_cfg_wdata;
                    CFG_PLAY_ONCE:   r_play_once   <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.restart || i_cmd.finish) begin
                r_frame <= '0;
            end else if (i_cmd.step) begin
                r_frame <= n_frame;
            end

            if (i_cmd.restart || i_cmd.stop) begin
                r_acc <= '0;
            end else if (i_cmd.acc_add) begin
                r_acc <= acc_sat;
            end else if (i_cmd.step) begin
                r_acc <= r_acc - {1'b0, len_eff};
            end

            if (i_cmd.restart || i_cmd.resume) begin
                r_playing <= 1'b1;
            end else if (i_cmd.finish || i_cmd.stop) begin
                r_playing <= 1'b0;
            end

            if (i_cmd.resume || i_cmd.stop) begin
                r_paused <= 1'b0;
            end else if (i_cmd.pause) begin
                r_paused <= 1'b1;
            end

            if (i_cmd.stop) begin
                r_shown <= '0;
            end else if (i_cmd.load_part) begin
                r_shown <= r_rd_entry[ENTRY_W-1:TIME_BITS];
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sprite_part = r_out_part;
    assign o_frame_index = r_out_frame;
    assign o_playing     = r_out_playing;
    assign o_paused      = r_out_paused;

endmodule

>>> rtl/core/sfs_ctrl.sv
`timescale 1ns / 1ps

module sfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sfs_pkg::t_status i_status,
    output sfs_pkg::t_cmd    o_cmd
);
    import sfs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_ADD    = 7'b0000100,
        ST_CMP    = 7'b0001000,
        ST_MOVE   = 7'b0010000,
        ST_LOAD0  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_DONE;
                case (i_status.action)
                    ACT_TICK: begin
                        if (i_status.playing && !i_status.paused) begin
                            n_state = ST_ADD;
                        end
                    end
                    ACT_START: begin
                        if (i_status.paused) begin
                            o_cmd.resume = 1'b1;
                        end else begin
                            o_cmd.restart = 1'b1;
                            n_state       = ST_LOAD0;
                        end
                    end
                    ACT_PAUSE: o_cmd.pause = 1'b1;
                    ACT_STOP:  o_cmd.stop  = 1'b1;
                    ACT_WRITE: o_cmd.write = 1'b1;
                    default: begin
                    end
                endcase
            end
            ST_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_CMP;
            end
            ST_CMP, ST_MOVE: begin
                o_cmd.load_part = (r_state == ST_MOVE);
                if (!i_status.covers) begin
                    n_state = ST_DONE;
                end else if (i_status.last_once) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MOVE;
                end
            end
            ST_LOAD0: begin
                o_cmd.load_part = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
